@@ sv/ipid_pkg.sv @@
// ----------------------------------------------------------------------------
// ipid_pkg
// Shared types, register indexes and constants of the incremental PID
// position controller.
// ----------------------------------------------------------------------------
package ipid_pkg;

  // Default sizes of the position counter and the control accumulator.
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int CONTROL_WIDTH_DEF = 48;

  // Operand widths of the error path.
  localparam int ERR_W  = 32;  // error, Q.8 degrees
  localparam int D1_W   = 33;  // first error difference
  localparam int D2_W   = 35;  // second error difference
  localparam int MULT_W = 16;  // gains and degrees per count
  localparam int STEP_W = $clog2(MULT_W);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEG_PER_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 3'd6;

  // Reset values: 360.0 degrees, about 360/840 degrees per count,
  // about 0.1 degrees tolerance and a drive limit of 100.
  localparam logic [23:0] TARGET_ANGLE_RST = 24'd92160;
  localparam logic [15:0] DEG_PER_CNT_RST  = 16'd28087;
  localparam logic [15:0] SETTLE_TOL_RST   = 16'd26;
  localparam logic [7:0]  DRIVE_LIMIT_RST  = 8'd100;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 48;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [23:0] target_angle;
    logic [15:0] degrees_per_count;
    logic [15:0] settle_tolerance;
    logic [7:0]  drive_limit;
  } ipid_cfg_t;

  // Result item, drive_level in the lowest bits.
  typedef struct packed {
    logic [31:0] error_angle;
    logic        settled;
    logic        dir_reverse;
    logic        dir_forward;
    logic [7:0]  drive_level;
  } ipid_res_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic signed_mult;
  } ipid_mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic last;
  } ipid_mac_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ANG,
    ST_ERR,
    ST_LOAD_P,
    ST_MUL_P,
    ST_LOAD_I,
    ST_MUL_I,
    ST_LOAD_D,
    ST_MUL_D,
    ST_ACC,
    ST_FIN
  } ipid_state_t;

endpackage

@@ sv/incremental_pid_position_controller_top.sv @@
// ----------------------------------------------------------------------------
// incremental_pid_position_controller_top
// Quadrature position count with an incremental PID position loop.
// ----------------------------------------------------------------------------
// Input items arrive on the in_ stream: in_tuser is the kind (0 for an edge
// on encoder channel B, 1 for a control tick) and in_tdata carries the two
// encoder levels. An edge moves the position count and gives no result.
// A tick gives exactly one result item on the out_ stream. A tick runs the
// angle, proportional, integral and derivative products in turn on the
// shared bit-serial multiplier; once the loop has settled, only the angle
// product is run. Registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while the block is idle, as the
// block itself does not enforce this. Reset loads the default gains, target,
// scale, tolerance and drive limit, and clears the count, error history,
// accumulator and the settled latch. A result waits in the output register
// while out_tready is low; the next item is still taken, and its result is
// held inside until the output register is free.
// ----------------------------------------------------------------------------
module incremental_pid_position_controller_top #(
  parameter int COUNT_WIDTH   = ipid_pkg::COUNT_WIDTH_DEF,
  parameter int CONTROL_WIDTH = ipid_pkg::CONTROL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ipid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipid_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // enc_a [0], enc_b [1], zero fill [7:2]
  input  logic [ipid_pkg::IN_TDATA_W-1:0]     in_tdata,
  // op [0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // drive_level [7:0], dir_forward [8], dir_reverse [9], settled [10],
  // error_angle [42:11], zero fill [47:43]
  output logic [ipid_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  ipid_pkg::ipid_cfg_t cfg_r;
  ipid_pkg::ipid_res_t res;
  ipid_pkg::ipid_res_t out_data_r;
  logic                out_valid_r;
  logic                res_valid;
  logic                res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p            <= '0;
      cfg_r.gain_i            <= '0;
      cfg_r.gain_d            <= '0;
      cfg_r.target_angle      <= ipid_pkg::TARGET_ANGLE_RST;
      cfg_r.degrees_per_count <= ipid_pkg::DEG_PER_CNT_RST;
      cfg_r.settle_tolerance  <= ipid_pkg::SETTLE_TOL_RST;
      cfg_r.drive_limit       <= ipid_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ipid_pkg::REG_GAIN_P:       cfg_r.gain_p            <= cfg_wdata[15:0];
        ipid_pkg::REG_GAIN_I:       cfg_r.gain_i            <= cfg_wdata[15:0];
        ipid_pkg::REG_GAIN_D:       cfg_r.gain_d            <= cfg_wdata[15:0];
        ipid_pkg::REG_TARGET_ANGLE: cfg_r.target_angle      <= cfg_wdata[23:0];
        ipid_pkg::REG_DEG_PER_CNT:  cfg_r.degrees_per_count <= cfg_wdata[15:0];
        ipid_pkg::REG_SETTLE_TOL:   cfg_r.settle_tolerance  <= cfg_wdata[15:0];
        ipid_pkg::REG_DRIVE_LIMIT:  cfg_r.drive_limit       <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  ipid_core #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .CONTROL_WIDTH (CONTROL_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_op     (in_tuser),
    .in_enc_a  (in_tdata[0]),
    .in_enc_b  (in_tdata[1]),
    .in_ready  (in_tready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // The output register frees up in the same cycle that its item is taken.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ipid_pkg::OUT_TDATA_W'(out_data_r);

endmodule

@@ sv/ipid_mac.sv @@
// ----------------------------------------------------------------------------
// ipid_mac
// Bit-serial shift-add multiply-accumulate unit: one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ipid_mac #(
  parameter int MCW = 35,
  parameter int PW  = 52
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ipid_pkg::ipid_mac_ctl_t         ctl,
  input  logic signed [MCW-1:0]           mcand,
  input  logic [ipid_pkg::MULT_W-1:0]     mult,
  output ipid_pkg::ipid_mac_sts_t         sts,
  output logic [PW-1:0]                   acc
);

  logic [PW-1:0]                   mcand_r;
  logic [ipid_pkg::MULT_W-1:0]     mult_r;
  logic [ipid_pkg::STEP_W-1:0]     step_r;
  logic                            busy_r;
  logic                            sgn_r;
  logic [PW-1:0]                   acc_r;
  logic [PW-1:0]                   acc_nxt;
  logic [PW-1:0]                   addend;
  logic                            last;

  always_comb begin
    addend = mult_r[0] ? mcand_r : '0;
    last   = busy_r && (step_r == ipid_pkg::STEP_W'(ipid_pkg::MULT_W - 1));
    acc_nxt = acc_r;
    if (ctl.load && ctl.clear) begin
      acc_nxt = '0;
    end else if (busy_r) begin
      // The top bit of a signed multiplier carries negative weight.
      if (last && sgn_r) begin
        acc_nxt = acc_r - addend;
      end else begin
        acc_nxt = acc_r + addend;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (ctl.load) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      busy_r <= !last;
      step_r <= step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (ctl.load) begin
      mcand_r <= PW'(mcand);
      mult_r  <= mult;
      sgn_r   <= ctl.signed_mult;
    end else if (busy_r) begin
      mcand_r <= mcand_r << 1;
      mult_r  <= mult_r >> 1;
    end
  end

  assign sts.busy = busy_r;
  assign sts.last = last;
  assign acc      = acc_r;

endmodule

@@ sv/ipid_core.sv @@
// ----------------------------------------------------------------------------
// ipid_core
// Sequencer and state of the controller: position count, error history,
// saturating control accumulator and the settled latch.
// ----------------------------------------------------------------------------
module ipid_core #(
  parameter int COUNT_WIDTH   = ipid_pkg::COUNT_WIDTH_DEF,
  parameter int CONTROL_WIDTH = ipid_pkg::CONTROL_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ipid_pkg::ipid_cfg_t cfg,
  input  logic                in_valid,
  input  logic                in_op,
  input  logic                in_enc_a,
  input  logic                in_enc_b,
  output logic                in_ready,
  output logic                res_valid,
  input  logic                res_ready,
  output ipid_pkg::ipid_res_t res
);

  localparam int MCW = (COUNT_WIDTH > ipid_pkg::D2_W) ? COUNT_WIDTH : ipid_pkg::D2_W;
  localparam int PW  = MCW + ipid_pkg::MULT_W + 1;
  localparam int DW  = PW - 7;
  localparam int CTW = CONTROL_WIDTH;
  localparam int SW  = ((CTW > PW) ? CTW : PW) + 1;
  localparam logic signed [CTW-1:0] ACC_MAX = {1'b0, {(CTW-1){1'b1}}};
  localparam logic signed [CTW-1:0] ACC_MIN = {1'b1, {(CTW-1){1'b0}}};

  ipid_pkg::ipid_state_t state_r, state_nxt;

  logic signed [COUNT_WIDTH-1:0]     count_r;
  logic signed [ipid_pkg::ERR_W-1:0] err_r, e1_r, e2_r;
  logic signed [CTW-1:0]             acc_r;
  logic                              settled_r;

  ipid_pkg::ipid_mac_ctl_t           mac_ctl;
  ipid_pkg::ipid_mac_sts_t           mac_sts;
  logic signed [MCW-1:0]             mac_mcand;
  logic [ipid_pkg::MULT_W-1:0]       mac_mult;
  logic [PW-1:0]                     mac_acc;

  logic                              in_fire;
  logic signed [ipid_pkg::D1_W-1:0]  d1;
  logic signed [ipid_pkg::D2_W-1:0]  d2;
  logic signed [PW-9:0]              angle;
  logic signed [DW-1:0]              err_diff;
  logic signed [ipid_pkg::ERR_W-1:0] err_nxt;
  logic signed [SW-1:0]              acc_sum;
  logic signed [CTW-1:0]             acc_nxt;
  logic [ipid_pkg::ERR_W-1:0]        err_mag;
  logic                              settled_nxt;
  logic [CTW-1:0]                    acc_mag;
  logic [CTW-17:0]                   drive_wide;
  logic [7:0]                        drive;

  ipid_mac #(
    .MCW (MCW),
    .PW  (PW)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .mcand (mac_mcand),
    .mult  (mac_mult),
    .sts   (mac_sts),
    .acc   (mac_acc)
  );

  assign in_fire = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipid_pkg::ST_IDLE:    if (in_fire && in_op) state_nxt = ipid_pkg::ST_MUL_ANG;
      ipid_pkg::ST_MUL_ANG: if (mac_sts.last) state_nxt = ipid_pkg::ST_ERR;
      ipid_pkg::ST_ERR:     state_nxt = ipid_pkg::ST_LOAD_P;
      ipid_pkg::ST_LOAD_P: begin
        state_nxt = settled_r ? ipid_pkg::ST_FIN : ipid_pkg::ST_MUL_P;
      end
      ipid_pkg::ST_MUL_P:   if (mac_sts.last) state_nxt = ipid_pkg::ST_LOAD_I;
      ipid_pkg::ST_LOAD_I:  state_nxt = ipid_pkg::ST_MUL_I;
      ipid_pkg::ST_MUL_I:   if (mac_sts.last) state_nxt = ipid_pkg::ST_LOAD_D;
      ipid_pkg::ST_LOAD_D:  state_nxt = ipid_pkg::ST_MUL_D;
      ipid_pkg::ST_MUL_D:   if (mac_sts.last) state_nxt = ipid_pkg::ST_ACC;
      ipid_pkg::ST_ACC:     state_nxt = ipid_pkg::ST_FIN;
      ipid_pkg::ST_FIN:     if (res_ready) state_nxt = ipid_pkg::ST_IDLE;
      default:              state_nxt = ipid_pkg::ST_IDLE;
    endcase
  end

  // Error differences for the proportional and derivative products.
  always_comb begin
    d1 = ipid_pkg::D1_W'(err_r) - ipid_pkg::D1_W'(e1_r);
    d2 = ipid_pkg::D2_W'(err_r) - (ipid_pkg::D2_W'(e1_r) <<< 1)
         + ipid_pkg::D2_W'(e2_r);
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready            = 1'b0;
    res_valid           = 1'b0;
    mac_ctl.load        = 1'b0;
    mac_ctl.clear       = 1'b0;
    mac_ctl.signed_mult = 1'b1;
    mac_mcand           = MCW'(err_r);
    mac_mult            = cfg.gain_i;
    case (state_r)
      ipid_pkg::ST_IDLE: begin
        in_ready            = 1'b1;
        mac_ctl.load        = in_fire && in_op;
        mac_ctl.clear       = 1'b1;
        mac_ctl.signed_mult = 1'b0;
        mac_mcand           = MCW'(count_r);
        mac_mult            = cfg.degrees_per_count;
      end
      ipid_pkg::ST_LOAD_P: begin
        mac_ctl.load  = !settled_r;
        mac_ctl.clear = 1'b1;
        mac_mcand     = MCW'(d1);
        mac_mult      = cfg.gain_p;
      end
      ipid_pkg::ST_LOAD_I: begin
        mac_ctl.load = 1'b1;
      end
      ipid_pkg::ST_LOAD_D: begin
        mac_ctl.load = 1'b1;
        mac_mcand    = MCW'(d2);
        mac_mult     = cfg.gain_d;
      end
      ipid_pkg::ST_FIN: begin
        res_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Angle is the product floored by eight fraction bits; the error saturates
  // to 32 bits.
  always_comb begin
    angle    = $signed(mac_acc[PW-1:8]);
    err_diff = DW'($signed(cfg.target_angle)) - DW'(angle);
    if (err_diff > DW'(ipid_pkg::ERR_MAX)) begin
      err_nxt = ipid_pkg::ERR_MAX;
    end else if (err_diff < DW'(ipid_pkg::ERR_MIN)) begin
      err_nxt = ipid_pkg::ERR_MIN;
    end else begin
      err_nxt = err_diff[ipid_pkg::ERR_W-1:0];
    end
  end

  always_comb begin
    acc_sum = SW'(acc_r) + SW'($signed(mac_acc));
    if (acc_sum > SW'(ACC_MAX)) begin
      acc_nxt = ACC_MAX;
    end else if (acc_sum < SW'(ACC_MIN)) begin
      acc_nxt = ACC_MIN;
    end else begin
      acc_nxt = acc_sum[CTW-1:0];
    end
  end

  // Result of the tick, formed from the settled latch as it will be after it.
  always_comb begin
    err_mag     = err_r[ipid_pkg::ERR_W-1] ? (~err_r + 1'b1) : err_r;
    settled_nxt = settled_r ||
                  (err_mag <= ipid_pkg::ERR_W'(cfg.settle_tolerance));
    acc_mag     = acc_r[CTW-1] ? (~acc_r + 1'b1) : acc_r;
    drive_wide  = acc_mag[CTW-1:16];
    if (drive_wide > (CTW-16)'(cfg.drive_limit)) begin
      drive = cfg.drive_limit;
    end else begin
      drive = drive_wide[7:0];
    end
    res.drive_level = settled_nxt ? 8'd0 : drive;
    res.dir_forward = !acc_r[CTW-1];
    res.dir_reverse = acc_r[CTW-1] || (acc_r == '0);
    res.settled     = settled_nxt;
    res.error_angle = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ipid_pkg::ST_IDLE;
      count_r   <= '0;
      e1_r      <= '0;
      e2_r      <= '0;
      acc_r     <= '0;
      settled_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire && !in_op) begin
        count_r <= (in_enc_a == in_enc_b) ? count_r + 1'b1 : count_r - 1'b1;
      end
      if (state_r == ipid_pkg::ST_ACC) begin
        acc_r <= acc_nxt;
        e2_r  <= e1_r;
        e1_r  <= err_r;
      end
      if (state_r == ipid_pkg::ST_FIN && res_ready) begin
        settled_r <= settled_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ipid_pkg::ST_ERR) begin
      err_r <= err_nxt;
    end
  end

  // The multiplier is only started when it has finished its last product.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mac_ctl.load |-> !mac_sts.busy)
    else $error("multiplier started while busy");

  // Only reset clears the settled latch.
  a_latch_holds: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(settled_r))
    else $error("settled latch cleared without reset");

  // Once settled, the accumulator and the error history are frozen.
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    settled_r |=> $stable(acc_r) && $stable(e1_r) && $stable(e2_r))
    else $error("control state changed after settling");

  // A result is offered only once the multiplier is quiet.
  a_res_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !mac_sts.busy)
    else $error("result offered while multiplier busy");

endmodule
